/* rtl/lcg64_random_mod_limit_unit_assert.svh */
// assertion macros used by the lcg64 controller
// no dependencies; define ASSERT_OFF to drop all checks
`ifndef LCG64_RANDOM_MOD_LIMIT_UNIT_ASSERT_SVH
`define LCG64_RANDOM_MOD_LIMIT_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
`define LCG64_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define LCG64_ASSERT_RESET(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LCG64_ASSERT(lbl, clk, rst, prop, msg)
`define LCG64_ASSERT_RESET(lbl, clk, prop, msg)
`endif

`endif

/* rtl/lcg64_pkg.sv */
// shared constants and controller/datapath types for the lcg64 unit
// no dependencies
`default_nettype none

package lcg64_pkg;

  localparam int WORD_W    = 64;
  localparam int HALF_W    = WORD_W / 2;
  localparam int MULT_W    = 28;
  localparam int INC_W     = 35;
  localparam int PROD_W    = MULT_W + HALF_W;
  localparam int PROD_LO_W = PROD_W + 1;

  localparam logic [MULT_W-1:0] LCG_MULT   = 28'd136204069;
  localparam logic [INC_W-1:0]  LCG_INC    = 35'd28500701229;
  localparam logic [WORD_W-1:0] SEED_RESET = 64'd1;

  typedef struct packed {
    logic load_seed;
    logic start;
    logic mul_lo;
    logic mul_hi;
    logic add;
    logic div_step;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic bound_zero;
  } dp_status_t;

endpackage

`default_nettype wire

/* rtl/lcg64_req_if.sv */
// request channel carrying the upper bound
// depends on lcg64_pkg
`default_nettype none

interface lcg64_req_if;
  logic                          valid;
  logic                          ready;
  logic [lcg64_pkg::WORD_W-1:0]  upper_bound;

  modport source (output valid, output upper_bound, input ready);
  modport sink (input valid, input upper_bound, output ready);
endinterface

`default_nettype wire

/* rtl/lcg64_rsp_if.sv */
// response channel carrying the reduced random number and zero-bound flag
// depends on lcg64_pkg
`default_nettype none

interface lcg64_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [lcg64_pkg::WORD_W-1:0]  random_out;
  logic                          bound_zero;

  modport source (output valid, output random_out, output bound_zero, input ready);
  modport sink (input valid, input random_out, input bound_zero, output ready);
endinterface

`default_nettype wire

/* rtl/lcg64_cfg_if.sv */
// configuration write channel carrying the seed value
// depends on lcg64_pkg
`default_nettype none

interface lcg64_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [lcg64_pkg::WORD_W-1:0]  seed_value;

  modport source (output valid, output seed_value, input ready);
  modport sink (input valid, input seed_value, output ready);
endinterface

`default_nettype wire

/* rtl/lcg64_datapath.sv */
// generator state, shared 28x32 multiplier, radix-2 remainder unit, result register
// depends on lcg64_pkg
`default_nettype none

module lcg64_datapath (
  input  wire                          clk,
  input  wire                          rst,
  input  lcg64_pkg::ctrl_cmd_t         cmd,
  output lcg64_pkg::dp_status_t        status,
  input  wire [lcg64_pkg::WORD_W-1:0]  seed_value,
  input  wire [lcg64_pkg::WORD_W-1:0]  upper_bound,
  output logic [lcg64_pkg::WORD_W-1:0] random_out,
  output logic                         bound_zero
);

  localparam int WORD_W    = lcg64_pkg::WORD_W;
  localparam int HALF_W    = lcg64_pkg::HALF_W;
  localparam int PROD_W    = lcg64_pkg::PROD_W;
  localparam int PROD_LO_W = lcg64_pkg::PROD_LO_W;

  logic [WORD_W-1:0]    gen_state;
  logic [WORD_W-1:0]    bound;
  logic                 zero_flag;
  logic [PROD_LO_W-1:0] prod_lo;
  logic [HALF_W-1:0]    prod_hi;
  logic [WORD_W-1:0]    dividend;
  logic [WORD_W-1:0]    rem;

  logic [HALF_W-1:0]    mul_a;
  logic [PROD_W-1:0]    mul_p;
  logic [WORD_W-1:0]    sum;
  logic [WORD_W:0]      shifted;
  logic [WORD_W+1:0]    diff;

  // one shared multiplier, low half then high half of the state
  assign mul_a   = cmd.mul_hi ? gen_state[WORD_W-1:HALF_W] : gen_state[HALF_W-1:0];
  assign mul_p   = PROD_W'(lcg64_pkg::LCG_MULT) * PROD_W'(mul_a);
  assign sum     = WORD_W'(prod_lo) + {prod_hi, {HALF_W{1'b0}}};

  // restoring remainder step
  assign shifted = {rem, dividend[WORD_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, bound};

  always_ff @(posedge clk) begin
    if (rst) begin
      gen_state <= lcg64_pkg::SEED_RESET;
    end else if (cmd.load_seed) begin
      gen_state <= seed_value;
    end else if (cmd.add) begin
      gen_state <= sum;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      bound     <= upper_bound;
      zero_flag <= (upper_bound == '0);
    end
    if (cmd.mul_lo) begin
      prod_lo <= PROD_LO_W'(mul_p) + PROD_LO_W'(lcg64_pkg::LCG_INC);
    end
    if (cmd.mul_hi) begin
      prod_hi <= mul_p[HALF_W-1:0];
    end
    if (cmd.add) begin
      dividend <= sum;
      rem      <= '0;
    end else if (cmd.div_step) begin
      dividend <= {dividend[WORD_W-2:0], 1'b0};
      rem      <= diff[WORD_W+1] ? shifted[WORD_W-1:0] : diff[WORD_W-1:0];
    end
    if (cmd.out_load) begin
      random_out <= zero_flag ? '0 : rem;
      bound_zero <= zero_flag;
    end
  end

  assign status.bound_zero = zero_flag;

endmodule

`default_nettype wire

/* rtl/lcg64_controller.sv */
// sequencer for load, multiply, add, 64 remainder steps (skipped for a zero bound) and result handoff
// depends on lcg64_pkg and the assertion macro header
`default_nettype none
`include "lcg64_random_mod_limit_unit_assert.svh"

module lcg64_controller (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     req_valid,
  output logic                    req_ready,
  input  wire                     cfg_valid,
  output logic                    cfg_ready,
  output logic                    rsp_valid,
  input  wire                     rsp_ready,
  output lcg64_pkg::ctrl_cmd_t    cmd,
  input  lcg64_pkg::dp_status_t   status
);

  localparam int DIV_STEPS = lcg64_pkg::WORD_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_LO,
    S_MUL_HI,
    S_ADD,
    S_DIV,
    S_FINISH
  } state_t;

  state_t            state;
  state_t            state_next;
  logic [CNT_W-1:0]  step_cnt;
  logic              out_free;

  assign out_free  = !rsp_valid || rsp_ready;
  assign cfg_ready = (state == S_IDLE);
  assign req_ready = (state == S_IDLE) && !cfg_valid;

  always_comb begin
    cmd            = '0;
    state_next     = state;
    cmd.load_seed  = cfg_valid && cfg_ready;
    case (state)
      S_IDLE: begin
        if (req_valid && req_ready) begin
          cmd.start  = 1'b1;
          state_next = S_MUL_LO;
        end
      end
      S_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_next = S_MUL_HI;
      end
      S_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_next = S_ADD;
      end
      S_ADD: begin
        cmd.add    = 1'b1;
        state_next = status.bound_zero ? S_FINISH : S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (step_cnt == CNT_LAST) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step_cnt  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DIV) begin
        step_cnt <= step_cnt + 1'b1;
      end else begin
        step_cnt <= '0;
      end
      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  `LCG64_ASSERT(a_accept_starts, clk, rst, req_valid && req_ready |=> state == S_MUL_LO, "accepted request did not start the multiply")
  `LCG64_ASSERT(a_div_ends, clk, rst, (state == S_DIV) && (step_cnt == CNT_LAST) |=> state == S_FINISH, "remainder loop did not end after last step")
  `LCG64_ASSERT(a_no_overwrite, clk, rst, cmd.out_load |-> out_free, "result loaded over an untaken response")
  `LCG64_ASSERT(a_one_phase, clk, rst, $onehot0({cmd.start, cmd.mul_lo, cmd.mul_hi, cmd.add, cmd.div_step, cmd.out_load}), "more than one datapath phase active")
  `LCG64_ASSERT_RESET(a_reset_idle, clk, rst |=> (state == S_IDLE) && !rsp_valid, "reset did not return to idle")

endmodule

`default_nettype wire

/* rtl/lcg64_random_mod_limit_unit.sv */
// Top level of the 64-bit linear congruential generator with per-request modulo limit.
// Depends on lcg64_pkg, the request/response/config interfaces, controller and datapath.
// Each request advances state = 136204069*state + 28500701229 (mod 2^64) and returns the
// new state modulo upper_bound; a zero bound returns 0 with bound_zero set. One request
// is handled at a time: a nonzero bound passes through the low and high halves on the
// shared 28x32 multiplier, one add, 64 steps of the radix-2 remainder loop and one output
// load, which waits until the output register is free; a zero bound skips the loop. No new
// request is taken until the last one is through. A finished response sits in an output
// register while the next request is accepted. Writing the seed reloads the state; the
// state resets to 1. Seed writes are taken only while no request is being worked on.
`default_nettype none

module lcg64_random_mod_limit_unit (
  input  wire          clk,
  input  wire          rst,
  lcg64_cfg_if.sink    cfg,
  lcg64_req_if.sink    req,
  lcg64_rsp_if.source  rsp
);

  lcg64_pkg::ctrl_cmd_t   cmd;
  lcg64_pkg::dp_status_t  status;

  lcg64_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .cfg_valid (cfg.valid),
    .cfg_ready (cfg.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd),
    .status    (status)
  );

  lcg64_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .seed_value  (cfg.seed_value),
    .upper_bound (req.upper_bound),
    .random_out  (rsp.random_out),
    .bound_zero  (rsp.bound_zero)
  );

endmodule

`default_nettype wire
